[rtl/sensor_packet_deframer_top_assert.svh]
// ----------------------------------------------------------------------------
// Sensor packet deframer assertion macros
// Shared assertion macros, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SENSOR_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define SENSOR_PACKET_DEFRAMER_TOP_ASSERT_SVH

`ifndef SYNTH
`define SPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("deframer assertion failed");
`define SPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer assertion failed");
`else
`define SPD_ASSERT(lbl, prop)
`define SPD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/spd_pkg.sv]
// ----------------------------------------------------------------------------
// Sensor packet deframer package
// Frame constants and the types shared by the deframer modules.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam logic [7:0] HDR_VITAL      = 8'hAA;
  localparam logic [7:0] HDR_REQ        = 8'hA5;
  localparam logic [7:0] REQ_CLOCK_CODE = 8'h01;
  localparam logic [7:0] SPO2_MAX       = 8'd100;
  localparam logic [7:0] FALL_MAX       = 8'd1;

  localparam int BUF_DEPTH = 7;
  localparam int VITAL_LEN = 7;
  localparam int REQ_LEN   = 3;
  localparam int TDATA_W   = 40;
  localparam int SPD_QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_DATA    = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_VITAL = 1'b0,
    KIND_REQ   = 1'b1
  } kind_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pulse_rate;
    logic [6:0]  oxygen_level;
    logic        fall_level;
    logic        fall_edge;
    logic [15:0] step_count;
  } res_t;

endpackage

[rtl/spd_front.sv]
// ----------------------------------------------------------------------------
// Sensor packet deframer front end
// Accepts stream words, tags each as data or session restart, and queues them.
// ----------------------------------------------------------------------------
module spd_front import spd_pkg::*; #(
  parameter int QueueDepth = SPD_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_byte
  input  logic       s_axis_tuser,   // restart
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output entry_t     entry_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  entry_t          q_mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            push, pop;
  entry_t          in_entry;

  assign s_axis_tready = (fill_q != CntW'(QueueDepth));
  assign pop_valid_o   = (fill_q != '0);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = pop_valid_o && pop_ready_i;
  assign entry_o       = q_mem[rd_ptr_q];

  assign in_entry.cmd  = s_axis_tuser ? CMD_RESTART : CMD_DATA;
  assign in_entry.data = s_axis_tdata;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= in_entry;
    end
  end

`include "sensor_packet_deframer_top_assert.svh"

  `SPD_ASSERT(a_fill_max, fill_q <= CntW'(QueueDepth))
  `SPD_ASSERT_NEXT(a_fill_step, push && !pop, fill_q == $past(fill_q) + 1'b1)
  `SPD_ASSERT_NEXT(a_fill_drop, pop && !push, fill_q == $past(fill_q) - 1'b1)

endmodule

[rtl/spd_scan.sv]
// ----------------------------------------------------------------------------
// Sensor packet deframer scan engine
// Holds the pending bytes, takes one scan step per cycle unless output back-pressure holds it, and registers results.
// ----------------------------------------------------------------------------
module spd_scan import spd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   pop_valid_i,
  output logic   pop_ready_o,
  input  entry_t entry_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output res_t   out_res_o,
  output logic   out_last_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  typedef enum logic [1:0] {
    ACT_DONE,
    ACT_DROP,
    ACT_VITAL,
    ACT_REQ
  } act_e;

  state_e     state_q, state_d;
  logic [7:0] buf_q [BUF_DEPTH];
  logic [7:0] buf_d [BUF_DEPTH];
  logic [2:0] cnt_q, cnt_d;
  logic       prev_fall_q, prev_fall_d;
  logic       hold_vld_q, hold_vld_d;
  res_t       hold_q, hold_d;
  logic       out_vld_q, out_vld_d;
  res_t       out_q, out_d;
  logic       out_last_q, out_last_d;

  act_e       act;
  logic [7:0] xsum;
  logic       vital_ok, req_ok, out_free;
  logic [2:0] drop_n;
  res_t       vital_res, req_res;

  assign xsum     = buf_q[0] ^ buf_q[1] ^ buf_q[2] ^ buf_q[3] ^ buf_q[4] ^ buf_q[5];
  assign vital_ok = (xsum == buf_q[6]) && (buf_q[2] <= SPO2_MAX) && (buf_q[3] <= FALL_MAX);
  assign req_ok   = (buf_q[1] == REQ_CLOCK_CODE) && ((buf_q[0] ^ buf_q[1]) == buf_q[2]);
  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    if (cnt_q == '0) begin
      act = ACT_DONE;
    end else if (buf_q[0] == HDR_VITAL) begin
      if (cnt_q < 3'(VITAL_LEN)) begin
        act = ACT_DONE;
      end else begin
        act = vital_ok ? ACT_VITAL : ACT_DROP;
      end
    end else if (buf_q[0] == HDR_REQ) begin
      if (cnt_q < 3'(REQ_LEN)) begin
        act = ACT_DONE;
      end else begin
        act = req_ok ? ACT_REQ : ACT_DROP;
      end
    end else begin
      act = ACT_DROP;
    end
  end

  always_comb begin
    vital_res.kind         = KIND_VITAL;
    vital_res.pulse_rate   = buf_q[1];
    vital_res.oxygen_level = buf_q[2][6:0];
    vital_res.fall_level   = buf_q[3][0];
    vital_res.fall_edge    = buf_q[3][0] && !prev_fall_q;
    vital_res.step_count   = {buf_q[5], buf_q[4]};
    req_res                = '0;
    req_res.kind           = KIND_REQ;
  end

  always_comb begin
    state_d     = state_q;
    buf_d       = buf_q;
    cnt_d       = cnt_q;
    prev_fall_d = prev_fall_q;
    hold_vld_d  = hold_vld_q;
    hold_d      = hold_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_d       = out_q;
    out_last_d  = out_last_q;
    pop_ready_o = 1'b0;
    drop_n      = '0;
    unique case (state_q)
      ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          if (entry_i.cmd == CMD_RESTART) begin
            cnt_d       = '0;
            prev_fall_d = 1'b0;
          end else begin
            buf_d[cnt_q] = entry_i.data;
            cnt_d        = cnt_q + 1'b1;
            state_d      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        unique case (act)
          ACT_DONE: begin
            if (!hold_vld_q) begin
              state_d = ST_IDLE;
            end else if (out_free) begin
              out_vld_d  = 1'b1;
              out_d      = hold_q;
              out_last_d = 1'b1;
              hold_vld_d = 1'b0;
              state_d    = ST_IDLE;
            end
          end
          ACT_DROP: begin
            drop_n = 3'd1;
          end
          ACT_VITAL, ACT_REQ: begin
            if (!hold_vld_q || out_free) begin
              if (hold_vld_q) begin
                out_vld_d  = 1'b1;
                out_d      = hold_q;
                out_last_d = 1'b0;
              end
              hold_vld_d = 1'b1;
              if (act == ACT_VITAL) begin
                hold_d      = vital_res;
                prev_fall_d = buf_q[3][0];
                drop_n      = 3'(VITAL_LEN);
              end else begin
                hold_d = req_res;
                drop_n = 3'(REQ_LEN);
              end
            end
          end
          default: begin
            drop_n = '0;
          end
        endcase
        cnt_d = cnt_q - drop_n;
        for (int i = 0; i < BUF_DEPTH - 1; i++) begin
          if (drop_n == 3'd1) begin
            buf_d[i] = buf_q[i + 1];
          end
        end
        for (int i = 0; i < BUF_DEPTH - REQ_LEN; i++) begin
          if (drop_n == 3'(REQ_LEN)) begin
            buf_d[i] = buf_q[i + REQ_LEN];
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      prev_fall_q <= 1'b0;
      hold_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      prev_fall_q <= prev_fall_d;
      hold_vld_q  <= hold_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q      <= buf_d;
    hold_q     <= hold_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

`include "sensor_packet_deframer_top_assert.svh"

  `SPD_ASSERT(a_idle_count, (state_q == ST_IDLE) |-> (cnt_q <= 3'd6))
  `SPD_ASSERT(a_hold_in_scan, hold_vld_q |-> (state_q == ST_SCAN))
  `SPD_ASSERT(a_more_pending, (out_vld_q && !out_last_q) |-> hold_vld_q)
  `SPD_ASSERT_NEXT(a_restart_fall,
    (state_q == ST_IDLE) && pop_valid_i && (entry_i.cmd == CMD_RESTART), !prev_fall_q)

endmodule

[rtl/sensor_packet_deframer_top.sv]
// ----------------------------------------------------------------------------
// Sensor packet deframer
// Input stream: one link byte per word in s_axis_tdata; s_axis_tuser high
// marks a session restart, which clears the pending bytes and the fall edge
// memory and ignores the byte. Output stream: one word per accepted frame,
// m_axis_tuser gives the kind (0 vital, 1 time request) and m_axis_tlast
// marks the last frame found for one input byte (at most two per byte).
// Input words enter a small queue, so s_axis_tready stays high while the
// queue has room, also while a result waits on the output.
// The scan engine takes one queued byte, then makes one step per cycle over
// its seven-byte window while the output does not hold it back: each step
// accepts a frame or drops one byte, and a last step finds an empty or
// incomplete window; a full window may thus be rescanned byte by byte.
// A result passes through a held frame register, then the output register.
// When the receiver stalls, the output register and one held frame fill and
// the scan engine waits, then the input queue fills and tready falls.
// Reset empties the queue, the pending bytes and the fall edge memory.
// ----------------------------------------------------------------------------
module sensor_packet_deframer_top import spd_pkg::*; #(
  parameter int QueueDepth = SPD_QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // data_byte
  input  logic               s_axis_tuser,   // restart
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // pulse_rate, oxygen_level, fall_level,
                                             // fall_edge, step_count, zero fill
  output logic               m_axis_tuser,   // kind
  output logic               m_axis_tlast    // last
);

  localparam int UsedW = 33;

  logic   pop_valid, pop_ready;
  entry_t entry;
  res_t   res;
  logic   res_last;

  spd_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .pop_valid_o   (pop_valid),
    .pop_ready_i   (pop_ready),
    .entry_o       (entry)
  );

  spd_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .entry_i     (entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .out_last_o  (res_last)
  );

  assign m_axis_tdata = {{(TDATA_W - UsedW){1'b0}}, res.step_count, res.fall_edge,
                         res.fall_level, res.oxygen_level, res.pulse_rate};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res_last;

endmodule
